/* sv/chr_pkg.sv */
// ----------------------------------------------------------------------------
// chr_pkg
// Shared types, sizes and codes of the consistent hash ring.
// ----------------------------------------------------------------------------
package chr_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int HASH_BITS   = 64;

    localparam int IDX_W = $clog2(MAX_SERVERS);
    localparam int CNT_W = $clog2(MAX_SERVERS + 1);

    localparam int ID_W   = 8;
    localparam int HASH_W = 64;

    typedef logic [1:0] func_t;
    localparam func_t FUNC_ADD    = 2'd0;
    localparam func_t FUNC_REMOVE = 2'd1;
    localparam func_t FUNC_LOOKUP = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_EMPTY     = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_NOT_FOUND = 2'd3;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // Keep the low HASH_BITS bits, sign-extended to the full word.
    function automatic logic signed [HASH_W-1:0] norm_hash(input logic [HASH_W-1:0] v);
        logic signed [HASH_W-1:0] t;
        t = $signed(v) <<< (HASH_W - HASH_BITS);
        return t >>> (HASH_W - HASH_BITS);
    endfunction

endpackage

/* sv/consistent_hash_ring.sv */
// ----------------------------------------------------------------------------
// consistent_hash_ring
// Sorted ring of server hashes with add, remove and key owner lookup.
// ----------------------------------------------------------------------------
// After input accept, the scan walks the sorted entries one compare per cycle
// (skipped on an empty ring); the finish step then waits for a free output.
// No new item is taken during a scan or the finish step.
// The result sits in an output register, so the next item is taken while it
// waits. Reset clears the entry count and control; entries need no clearing.
module consistent_hash_ring
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // hash_value[63:0], node_id[71:64]
    input  logic [1:0]   s_tuser,   // func[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // owner_id[7:0], range_start[71:8], range_end[135:72]
    output logic [1:0]   m_tuser    // status[1:0]
);

    localparam int IDX_W  = chr_pkg::IDX_W;
    localparam int CNT_W  = chr_pkg::CNT_W;
    localparam int HASH_W = chr_pkg::HASH_W;
    localparam int ID_W   = chr_pkg::ID_W;
    localparam int NSRV   = chr_pkg::MAX_SERVERS;

    // ring storage, sorted ascending by signed hash
    logic signed [HASH_W-1:0] ring_hash [NSRV];
    logic [ID_W-1:0]          ring_owner [NSRV];
    logic [CNT_W-1:0]         count_reg;

    chr_pkg::state_t state_reg, state_next;

    // latched item
    chr_pkg::func_t           func_reg;
    logic signed [HASH_W-1:0] h_reg;
    logic [ID_W-1:0]          id_reg;

    // scan captures
    logic [IDX_W-1:0]         scan_reg;
    logic                     found_reg, eq_reg, just_reg;
    logic [IDX_W-1:0]         pos_reg;
    logic signed [HASH_W-1:0] pos_hash_reg, prev_at_pos_reg, prev_reg;
    logic signed [HASH_W-1:0] first_hash_reg, last_hash_reg;
    logic [ID_W-1:0]          pos_owner_reg, first_owner_reg, next_owner_reg;

    // output register
    logic                     m_valid_reg;
    chr_pkg::status_t         st_reg;
    logic [ID_W-1:0]          o_owner_reg;
    logic signed [HASH_W-1:0] o_start_reg, o_end_reg;

    // control from the finish step
    logic                     in_acc, scan_last, out_free, commit;
    logic                     do_ins, do_del, do_upd;
    chr_pkg::status_t         r_status;
    logic [ID_W-1:0]          r_owner;
    logic signed [HASH_W-1:0] r_start, r_end;
    logic signed [HASH_W-1:0] pred_sel;
    logic [IDX_W-1:0]         ins_pos;
    logic [CNT_W-1:0]         count_m1;
    logic signed [HASH_W-1:0] e_hash;
    logic [ID_W-1:0]          e_owner;

    // neighbor taps for the ring shift on insert and delete
    logic signed [HASH_W-1:0] below_hash [NSRV];
    logic [ID_W-1:0]          below_owner [NSRV];
    logic signed [HASH_W-1:0] above_hash [NSRV];
    logic [ID_W-1:0]          above_owner [NSRV];

    for (genvar j = 0; j < NSRV; j++)
    begin : g_nb
        if (j == 0)
        begin : g_lo
            assign below_hash[j]  = h_reg;
            assign below_owner[j] = id_reg;
        end
        else
        begin : g_mid
            assign below_hash[j]  = ring_hash[j-1];
            assign below_owner[j] = ring_owner[j-1];
        end
        if (j == NSRV - 1)
        begin : g_hi
            assign above_hash[j]  = ring_hash[j];
            assign above_owner[j] = ring_owner[j];
        end
        else
        begin : g_up
            assign above_hash[j]  = ring_hash[j+1];
            assign above_owner[j] = ring_owner[j+1];
        end
    end

    assign e_hash    = ring_hash[scan_reg];
    assign e_owner   = ring_owner[scan_reg];
    assign count_m1  = count_reg - CNT_W'(1);
    assign scan_last = (CNT_W'(scan_reg) == count_m1);
    assign out_free  = !m_valid_reg || m_tready;
    assign in_acc    = s_tvalid && s_tready;
    assign commit    = (state_reg == chr_pkg::S_FINISH) && out_free;
    assign pred_sel  = (pos_reg == '0) ? last_hash_reg : prev_at_pos_reg;
    assign ins_pos   = found_reg ? pos_reg : count_reg[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        do_upd     = 1'b0;
        r_status   = chr_pkg::ST_OK;
        r_owner    = '0;
        r_start    = '0;
        r_end      = '0;

        unique case (func_reg)
            chr_pkg::FUNC_ADD:
            begin
                if (found_reg && eq_reg)
                begin
                    do_upd  = 1'b1;
                    r_owner = id_reg;
                    r_start = pred_sel;
                    r_end   = h_reg;
                end
                else if (count_reg >= CNT_W'(NSRV))
                begin
                    r_status = chr_pkg::ST_FULL;
                end
                else
                begin
                    do_ins  = 1'b1;
                    r_owner = id_reg;
                    r_end   = h_reg;
                    if (found_reg)
                        r_start = pred_sel;
                    else if (count_reg == '0)
                        r_start = h_reg;
                    else
                        r_start = last_hash_reg;
                end
            end
            chr_pkg::FUNC_REMOVE:
            begin
                if (count_reg == '0)
                    r_status = chr_pkg::ST_EMPTY;
                else if (!(found_reg && eq_reg))
                    r_status = chr_pkg::ST_NOT_FOUND;
                else
                begin
                    do_del  = 1'b1;
                    r_owner = (CNT_W'(pos_reg) == count_m1) ? first_owner_reg
                                                            : next_owner_reg;
                    r_start = pred_sel;
                    r_end   = h_reg;
                end
            end
            chr_pkg::FUNC_LOOKUP:
            begin
                if (count_reg == '0)
                    r_status = chr_pkg::ST_EMPTY;
                else if (found_reg)
                begin
                    r_owner = pos_owner_reg;
                    r_start = pred_sel;
                    r_end   = pos_hash_reg;
                end
                else
                begin
                    // past the highest server: wrap to the lowest
                    r_owner = first_owner_reg;
                    r_start = last_hash_reg;
                    r_end   = first_hash_reg;
                end
            end
            default:
            begin
                r_status = chr_pkg::ST_OK;
            end
        endcase

        unique case (state_reg)
            chr_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = (count_reg == '0) ? chr_pkg::S_FINISH : chr_pkg::S_SCAN;
            end
            chr_pkg::S_SCAN:
            begin
                if (scan_last)
                    state_next = chr_pkg::S_FINISH;
            end
            chr_pkg::S_FINISH:
            begin
                if (out_free)
                    state_next = chr_pkg::S_IDLE;
            end
            default:
            begin
                state_next = chr_pkg::S_IDLE;
            end
        endcase

        if (!commit)
        begin
            do_ins = 1'b0;
            do_del = 1'b0;
            do_upd = 1'b0;
        end
    end

    // item latch and scan
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg  <= s_tuser;
            h_reg     <= chr_pkg::norm_hash(s_tdata[63:0]);
            id_reg    <= s_tdata[71:64];
            scan_reg  <= '0;
            found_reg <= 1'b0;
            eq_reg    <= 1'b0;
            just_reg  <= 1'b0;
        end
        else if (state_reg == chr_pkg::S_SCAN)
        begin
            if (scan_reg == '0)
            begin
                first_hash_reg  <= e_hash;
                first_owner_reg <= e_owner;
            end
            if (!found_reg && (h_reg <= e_hash))
            begin
                found_reg       <= 1'b1;
                eq_reg          <= (h_reg == e_hash);
                pos_reg         <= scan_reg;
                pos_hash_reg    <= e_hash;
                pos_owner_reg   <= e_owner;
                prev_at_pos_reg <= prev_reg;
                just_reg        <= 1'b1;
            end
            else
            begin
                just_reg <= 1'b0;
            end
            // successor of the hit entry
            if (just_reg)
                next_owner_reg <= e_owner;
            prev_reg      <= e_hash;
            last_hash_reg <= e_hash;
            scan_reg      <= scan_reg + IDX_W'(1);
        end
    end

    // ring update: on commit in the finish state, lanes from the position up shift for insert or delete
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NSRV; j++)
        begin
            if (do_ins && (IDX_W'(j) == ins_pos))
            begin
                ring_hash[j]  <= h_reg;
                ring_owner[j] <= id_reg;
            end
            else if (do_ins && (IDX_W'(j) > ins_pos) && (CNT_W'(j) <= count_reg))
            begin
                ring_hash[j]  <= below_hash[j];
                ring_owner[j] <= below_owner[j];
            end
            else if (do_del && (IDX_W'(j) >= pos_reg) && (CNT_W'(j) < count_m1))
            begin
                ring_hash[j]  <= above_hash[j];
                ring_owner[j] <= above_owner[j];
            end
            else if (do_upd && (IDX_W'(j) == pos_reg))
            begin
                ring_owner[j] <= id_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_ins)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_del)
                count_reg <= count_m1;

            if (commit)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            st_reg      <= r_status;
            o_owner_reg <= r_owner;
            o_start_reg <= r_start;
            o_end_reg   <= r_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = st_reg;
    assign m_tdata  = {o_end_reg, o_start_reg, o_owner_reg};

endmodule
